// ===== rtl/core/cpr_pkg.sv =====
`timescale 1ns / 1ps

package cpr_pkg;

    localparam int unsigned C_PAGE_W      = 16;
    localparam int unsigned C_FRAME_IDX_W = 3;
    localparam int unsigned C_COUNT_W     = 32;
    localparam int unsigned C_CFG_W       = 4;

    localparam logic [C_CFG_W-1:0]   C_FRAMES_RESET = 4'd8;
    localparam logic [C_COUNT_W-1:0] C_COUNT_MAX    = '1;

    typedef struct packed {
        logic [C_PAGE_W-1:0] page;
        logic                end_of_string;
    } t_cpr_in;

    typedef struct packed {
        logic                     hit;
        logic [C_FRAME_IDX_W-1:0] frame_index;
        logic [C_COUNT_W-1:0]     fault_count;
    } t_cpr_out;

endpackage

// ===== rtl/core/cpr_page_ram.sv =====
`timescale 1ns / 1ps

module cpr_page_ram #(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned WIDTH = 16,
    parameter int unsigned AW    = 3
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cpr_engine.sv =====
`timescale 1ns / 1ps

module cpr_engine
    import cpr_pkg::*;
#(
    parameter int unsigned FRAMES    = 8,
    parameter int unsigned PAGE_BITS = 16,
    parameter int unsigned IDX_W     = 3,
    parameter int unsigned CNT_W     = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CNT_W-1:0]     i_active,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_cpr_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_cpr_out             o_out_data,
    output logic                 o_ram_we,
    output logic [IDX_W-1:0]     o_ram_waddr,
    output logic [PAGE_BITS-1:0] o_ram_wdata,
    output logic                 o_ram_re,
    output logic [IDX_W-1:0]     o_ram_raddr,
    input  logic [PAGE_BITS-1:0] i_ram_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [PAGE_BITS-1:0] r_key;
    logic                 r_last;
    logic [CNT_W-1:0]     r_scan;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_cmp_vld;
    logic [FRAMES-1:0]    r_vld;
    logic [FRAMES-1:0]    r_ref;
    logic [IDX_W-1:0]     r_hand;
    logic [C_COUNT_W-1:0] r_faults;
    logic [IDX_W-1:0]     r_slot;
    logic                 r_hit;
    logic                 r_out_valid;
    t_cpr_out             r_out;

    logic             w_issue;
    logic             w_match;
    logic             w_cmp_last;
    logic [CNT_W-1:0] w_hand_inc;
    logic [IDX_W-1:0] n_hand;
    logic             w_out_free;

    assign w_issue    = (r_state == S_LOOK) && (r_scan < i_active);
    assign w_match    = r_cmp_vld && r_vld[r_cmp_idx] && (i_ram_rdata == r_key);
    assign w_cmp_last = r_cmp_vld && ((CNT_W'(r_cmp_idx) + CNT_W'(1)) == i_active);
    assign w_hand_inc = CNT_W'(r_hand) + CNT_W'(1);
    assign n_hand     = (w_hand_inc >= i_active) ? '0 : w_hand_inc[IDX_W-1:0];
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_ram_re    = w_issue;
    assign o_ram_raddr = r_scan[IDX_W-1:0];
    assign o_ram_we    = (r_state == S_SWEEP) && !r_ref[r_hand];
    assign o_ram_waddr = r_hand;
    assign o_ram_wdata = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_vld       <= '0;
            r_ref       <= '0;
            r_hand      <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            r_cmp_vld <= w_issue;
            if (w_issue) begin
                r_cmp_idx <= r_scan[IDX_W-1:0];
                r_scan    <= r_scan + CNT_W'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_key     <= PAGE_BITS'(i_in_data.page);
                        r_last    <= i_in_data.end_of_string;
                        r_scan    <= '0;
                        r_state   <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (w_match) begin
                        r_ref[r_cmp_idx] <= 1'b1;
                        r_slot           <= r_cmp_idx;
                        r_hit            <= 1'b1;
                        r_state          <= S_DONE;
                    end else if (w_cmp_last) begin
                        r_hit <= 1'b0;
                        if (r_faults != C_COUNT_MAX) begin
                            r_faults <= r_faults + C_COUNT_W'(1);
                        end
                        // hand left beyond a shrunk frame count restarts at zero
                        if (CNT_W'(r_hand) >= i_active) begin
                            r_hand <= '0;
                        end
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_ref[r_hand]) begin
                        r_ref[r_hand] <= 1'b0;
                    end else begin
                        r_vld[r_hand] <= 1'b1;
                        r_ref[r_hand] <= 1'b1;
                        r_slot        <= r_hand;
                        r_state       <= S_DONE;
                    end
                    r_hand <= n_hand;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.hit         <= r_hit;
                        r_out.frame_index <= C_FRAME_IDX_W'(r_slot);
                        r_out.fault_count <= r_faults;
                        if (r_last) begin
                            r_vld    <= '0;
                            r_ref    <= '0;
                            r_hand   <= '0;
                            r_faults <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fault_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.hit) |-> (r_out.fault_count != '0))
        else $error("fault beat carries a zero fault count");

    a_hit_sets_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && w_match) |=> r_ref[$past(r_cmp_idx)])
        else $error("hit did not set the reference bit");

    a_fill_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && !r_ref[r_hand]) |=> r_vld[$past(r_hand)])
        else $error("replaced frame not marked valid");

    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (CNT_W'(r_hand) < i_active))
        else $error("clock hand outside active frames during sweep");

    a_no_write_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_re |-> !o_ram_we)
        else $error("page memory read and write overlap");

endmodule

// ===== rtl/core/clock_page_replacement_unit.sv =====
`timescale 1ns / 1ps
// each beat: accept, then a lookup with one page memory read per active frame,
// on a miss a clock hand sweep that replaces a frame, then the result
// one reference in flight; the next is taken while the previous result waits
// synchronous active-low reset: frames empty, hand and fault count zero, frame count 8

module clock_page_replacement_unit
    import cpr_pkg::*;
#(
    parameter int unsigned FRAMES    = 8,
    parameter int unsigned PAGE_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_cpr_in            i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_cpr_out           o_out_data,
    input  logic               i_cfg_we,
    input  logic [C_CFG_W-1:0] i_cfg_wdata
);

    localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned CNT_W = $clog2(FRAMES + 1);

    logic [C_CFG_W-1:0]   r_frames;
    logic [CNT_W-1:0]     w_active;
    logic                 w_ram_we;
    logic [IDX_W-1:0]     w_ram_waddr;
    logic [PAGE_BITS-1:0] w_ram_wdata;
    logic                 w_ram_re;
    logic [IDX_W-1:0]     w_ram_raddr;
    logic [PAGE_BITS-1:0] w_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= C_FRAMES_RESET;
        end else if (i_cfg_we) begin
            r_frames <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_frames == '0) begin
            w_active = CNT_W'(1);
        end else if (32'(r_frames) > 32'(FRAMES)) begin
            w_active = CNT_W'(FRAMES);
        end else begin
            w_active = CNT_W'(r_frames);
        end
    end

    cpr_page_ram #(
        .DEPTH (FRAMES),
        .WIDTH (PAGE_BITS),
        .AW    (IDX_W)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    cpr_engine #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_active    (w_active),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

endmodule
